[rtl/ltc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types and codes for the loop trip count block.
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam logic [2:0] KIND_EQ = 3'd0;
  localparam logic [2:0] KIND_NE = 3'd1;
  localparam logic [2:0] KIND_LT = 3'd2;
  localparam logic [2:0] KIND_LE = 3'd3;
  localparam logic [2:0] KIND_GT = 3'd4;
  localparam logic [2:0] KIND_GE = 3'd5;

  localparam int unsigned DIV_W = 32;
  localparam int unsigned QDEPTH = 2;

  // Classified request as handed from the front end to the divider.
  typedef struct packed {
    logic              bypass;      // result settled without a division
    logic              bypass_known;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
    logic              add1;
    logic              exact;       // remainder must be zero
  } cls_t;

endpackage

[rtl/ltc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_front
// Classifies a request and prepares the unsigned division operands.
// ----------------------------------------------------------------------------
module ltc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [2:0]         kind,
  input  logic signed [31:0] s,
  input  logic signed [31:0] l,
  input  logic signed [31:0] d,
  output logic               vld_r,
  output ltc_pkg::cls_t      cls_r
);

  logic signed [32:0] span;
  logic signed [32:0] nspan;
  logic [31:0]        den;
  logic [31:0]        mag;
  ltc_pkg::cls_t      cls_nxt;

  assign span  = {l[31], l} - {s[31], s};
  assign nspan = -span;
  assign den   = d[31] ? (~d + 32'd1) : d;
  assign mag   = span[32] ? nspan[31:0] : span[31:0];

  always_comb begin
    cls_nxt = '0;
    cls_nxt.den = den;
    cls_nxt.bypass = 1'b1;
    case (kind)
      ltc_pkg::KIND_LT: begin
        if (d == 0) cls_nxt.bypass_known = 1'b0;
        else if (!(s < l)) cls_nxt.bypass_known = 1'b1;
        else if (d < 0) cls_nxt.bypass_known = 1'b0;
        else begin
          cls_nxt.bypass = 1'b0;
          cls_nxt.num = span[31:0] - 32'd1;
          cls_nxt.add1 = 1'b1;
        end
      end
      ltc_pkg::KIND_LE: begin
        if (d == 0) cls_nxt.bypass_known = 1'b0;
        else if (!(s <= l)) cls_nxt.bypass_known = 1'b1;
        else if (d < 0) cls_nxt.bypass_known = 1'b0;
        else begin
          cls_nxt.bypass = 1'b0;
          cls_nxt.num = span[31:0];
          cls_nxt.add1 = 1'b1;
        end
      end
      ltc_pkg::KIND_GT: begin
        if (d == 0) cls_nxt.bypass_known = 1'b0;
        else if (!(s > l)) cls_nxt.bypass_known = 1'b1;
        else if (d > 0) cls_nxt.bypass_known = 1'b0;
        else begin
          cls_nxt.bypass = 1'b0;
          cls_nxt.num = nspan[31:0] - 32'd1;
          cls_nxt.add1 = 1'b1;
        end
      end
      ltc_pkg::KIND_GE: begin
        if (d == 0) cls_nxt.bypass_known = 1'b0;
        else if (!(s >= l)) cls_nxt.bypass_known = 1'b1;
        else if (d > 0) cls_nxt.bypass_known = 1'b0;
        else begin
          cls_nxt.bypass = 1'b0;
          cls_nxt.num = nspan[31:0];
          cls_nxt.add1 = 1'b1;
        end
      end
      ltc_pkg::KIND_NE: begin
        if (d == 0) cls_nxt.bypass_known = 1'b0;
        else if (s == l) cls_nxt.bypass_known = 1'b1;
        else if (span[32] != d[31]) cls_nxt.bypass_known = 1'b0;
        else begin
          cls_nxt.bypass = 1'b0;
          cls_nxt.num = mag;
          cls_nxt.exact = 1'b1;
        end
      end
      default: cls_nxt.bypass_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= acc;
    cls_r <= cls_nxt;
  end

endmodule

[rtl/ltc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_queue
// Two-entry queue between the classifier and the divider pipeline.
// ----------------------------------------------------------------------------
module ltc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ltc_pkg::cls_t wdata,
  output logic          full,
  output logic          pop,
  output ltc_pkg::cls_t rdata
);

  ltc_pkg::cls_t mem_r [ltc_pkg::QDEPTH];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  // The divider takes a request every cycle, so the head leaves at once.
  assign pop   = (cnt_r != 2'd0);
  assign full  = (cnt_r == 2'(ltc_pkg::QDEPTH));
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

[rtl/ltc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_back
// Pipelined restoring divider, one quotient bit per stage, then the
// final count adjustment and range check.
// ----------------------------------------------------------------------------
module ltc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  ltc_pkg::cls_t cls,
  output logic          out_vld_r,
  output logic          known_r,
  output logic [30:0]   count_r
);

  localparam int unsigned N = ltc_pkg::DIV_W;

  logic [N:0]    vld_r;
  ltc_pkg::cls_t st_r    [N+1];
  logic [N-1:0]  rem_r   [N+1];
  logic [N-1:0]  quo_r   [N+1];
  ltc_pkg::cls_t st_nxt  [N+1];
  logic [N-1:0]  rem_nxt [N+1];
  logic [N-1:0]  quo_nxt [N+1];
  logic [N:0]    sh      [1:N];
  logic [N:0]    diff    [1:N];

  logic [N:0]    cnt;
  logic          known_nxt;
  logic [30:0]   count_nxt;

  always_comb begin
    st_nxt[0]  = cls;
    rem_nxt[0] = '0;
    quo_nxt[0] = '0;
    for (int k = 1; k <= N; k++) begin
      sh[k]         = {rem_r[k-1], st_r[k-1].num[N-1]};
      diff[k]       = sh[k] - {1'b0, st_r[k-1].den};
      st_nxt[k]     = st_r[k-1];
      st_nxt[k].num = {st_r[k-1].num[N-2:0], 1'b0};
      if (!diff[k][N]) begin
        rem_nxt[k] = diff[k][N-1:0];
        quo_nxt[k] = {quo_r[k-1][N-2:0], 1'b1};
      end else begin
        rem_nxt[k] = sh[k][N-1:0];
        quo_nxt[k] = {quo_r[k-1][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[N-1:0], in_vld};
    for (int k = 0; k <= N; k++) begin
      st_r[k]  <= st_nxt[k];
      rem_r[k] <= rem_nxt[k];
      quo_r[k] <= quo_nxt[k];
    end
  end

  assign cnt = {1'b0, quo_r[N]} + {{N{1'b0}}, st_r[N].add1};

  always_comb begin
    known_nxt = 1'b0;
    count_nxt = '0;
    if (st_r[N].bypass) begin
      known_nxt = st_r[N].bypass_known;
    end else if (cnt[N:31] == '0 && !(st_r[N].exact && rem_r[N] != '0)) begin
      known_nxt = 1'b1;
      count_nxt = cnt[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= vld_r[N];
    known_r <= known_nxt;
    count_r <= count_nxt;
  end

endmodule

[rtl/loop_trip_count.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loop_trip_count
// Trip count of a counted loop with a constant signed step.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low.
// It carries the compare kind, the start value, the bound and the step.
// The classifier registers the request and settles the cases that need no
// division; everything passes a two-entry queue into a 32-stage divider
// pipeline that produces one quotient bit per stage, followed by a stage
// that adds the ceiling/floor correction and checks the int32 range.
// From acceptance to out_strobe a request passes the classifier, the queue, the
// divider input stage, the 32 divider stages and the output register. A new
// request may be taken every cycle while busy is low; results leave in order.
// Each result is shown for exactly one cycle with out_strobe high; the
// receiver cannot stall, and the divider never stops, so busy stays low.
// A synchronous reset (rst_n low) drops all requests in flight.
// ----------------------------------------------------------------------------
module loop_trip_count (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_compare_kind,
  input  logic signed [31:0] in_start_value,
  input  logic signed [31:0] in_limit_value,
  input  logic signed [31:0] in_stride,
  output logic               out_strobe,
  output logic               out_count_known,
  output logic [30:0]        out_trip_count
);

  logic          acc;
  logic          f_vld;
  ltc_pkg::cls_t f_cls;
  logic          q_full;
  logic          q_pop;
  ltc_pkg::cls_t q_cls;

  assign busy = q_full;
  assign acc  = start && !busy;

  ltc_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .kind(in_compare_kind),
    .s(in_start_value), .l(in_limit_value), .d(in_stride),
    .vld_r(f_vld), .cls_r(f_cls)
  );

  ltc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(f_vld), .wdata(f_cls),
    .full(q_full), .pop(q_pop), .rdata(q_cls)
  );

  ltc_back u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(q_pop), .cls(q_cls),
    .out_vld_r(out_strobe), .known_r(out_count_known), .count_r(out_trip_count)
  );

  a_zero_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_count_known |-> out_trip_count == '0)
    else $error("unknown count carries a nonzero value");

  a_no_full: assert property (@(posedge clk) disable iff (!rst_n) !q_full)
    else $error("queue filled although the divider never stalls");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

endmodule
